FILE: design/sha256sh_pkg.sv
// Shared types, constants and functions of the SHA-256 stream hasher.
// No dependencies; every other design file refers to this package by scoped names.

package sha256sh_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
        word_t f;
        word_t g;
        word_t h;
    } work_t;

    typedef struct packed {
        logic byte_en;
        logic round_en;
        logic early;
    } sched_ctrl_t;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LEN_START     = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [5:0] LAST_BYTE     = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    localparam work_t HASH_INIT = '{
        a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
        e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

FILE: design/sha256sh_sched.sv
// Sixteen-word message window: packs incoming bytes big-endian and then
// produces one schedule word per round. Depends on sha256sh_pkg.

module sha256sh_sched
(
    input  logic                      clk,
    input  sha256sh_pkg::sched_ctrl_t ctrl,
    input  logic [7:0]                byte_in,
    output sha256sh_pkg::word_t       w_out
);

    sha256sh_pkg::word_t win_reg [16];
    sha256sh_pkg::word_t win_next [16];
    sha256sh_pkg::word_t w_calc;

    always_comb
    begin
        w_calc = sha256sh_pkg::small_sigma1(win_reg[14]) + win_reg[9]
               + sha256sh_pkg::small_sigma0(win_reg[1]) + win_reg[0];
        w_out  = ctrl.early ? win_reg[0] : w_calc;
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctrl.byte_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], byte_in};
        end
        else if (ctrl.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = w_out;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

FILE: design/sha256sh_round.sv
// One SHA-256 compression round, shared by all 64 rounds of a block.
// Depends on sha256sh_pkg.

module sha256sh_round
(
    input  sha256sh_pkg::work_t cur,
    input  sha256sh_pkg::word_t w,
    input  sha256sh_pkg::word_t k,
    output sha256sh_pkg::work_t nxt
);

    sha256sh_pkg::word_t ch;
    sha256sh_pkg::word_t maj;
    sha256sh_pkg::word_t t1;
    sha256sh_pkg::word_t t2;

    always_comb
    begin
        ch  = (cur.e & cur.f) ^ (~cur.e & cur.g);
        maj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
        t1  = cur.h + sha256sh_pkg::big_sigma1(cur.e) + ch + k + w;
        t2  = sha256sh_pkg::big_sigma0(cur.a) + maj;
        nxt.h = cur.g;
        nxt.g = cur.f;
        nxt.f = cur.e;
        nxt.e = cur.d + t1;
        nxt.d = cur.c;
        nxt.c = cur.b;
        nxt.b = cur.a;
        nxt.a = t1 + t2;
    end

endmodule

FILE: design/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: sequencer, hash state and output port.
// Depends on sha256sh_pkg, sha256sh_sched and sha256sh_round.
//
// Usage: the input stream carries one message byte per beat in s_axis_tdata,
// with s_axis_tuser low. A beat with s_axis_tuser high ends the message; its
// data is ignored. The block pads the message, finishes the hash and sends
// the digest as eight beats on the output stream, word 0 (most significant)
// first, with the word position in m_axis_tuser and m_axis_tlast on word 7.
// Flow: the 64th byte of a block starts the compression, which runs all 64
// rounds on one shared round unit and then folds the result into the hash
// state; no byte is taken while a block is being compressed. The end beat
// feeds padding bytes one per cycle (up to 71), paused by one or two
// compressions, then the eight digest beats.
// s_axis_tready is high only while the block waits for the next byte.
// When the receiver stalls, the current digest word is held until taken.
// Reset restores the initial hash values and an empty message; the next
// message starts right after the last digest beat.

module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_ROUND  = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [5:0]          fill_reg, fill_next;
    logic [60:0]         count_reg, count_next;
    logic [5:0]          round_reg, round_next;
    logic                final_reg, final_next;
    logic                len_ok_reg, len_ok_next;
    logic [2:0]          idx_reg, idx_next;
    sha256sh_pkg::work_t hash_reg, hash_next;
    sha256sh_pkg::work_t work_reg, work_next;

    sha256sh_pkg::sched_ctrl_t sched_ctrl;
    sha256sh_pkg::word_t       w_word;
    sha256sh_pkg::work_t       round_out;
    logic                      in_fire;
    logic                      push_en;
    logic [7:0]                push_byte;
    logic [63:0]               len_shift;

    sha256sh_sched u_sched
    (
        .clk     (clk),
        .ctrl    (sched_ctrl),
        .byte_in (push_byte),
        .w_out   (w_word)
    );

    sha256sh_round u_round
    (
        .cur (work_reg),
        .w   (w_word),
        .k   (sha256sh_pkg::ROUND_K[round_reg]),
        .nxt (round_out)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign push_en       = in_fire || (state_reg == ST_PAD);
    assign len_shift     = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};

    always_comb
    begin
        push_byte = 8'h00;
        if (state_reg == ST_IDLE)
        begin
            push_byte = (s_axis_tuser == sha256sh_pkg::KIND_DATA) ? s_axis_tdata
                                                                  : sha256sh_pkg::PAD_MARK;
        end
        else if (len_ok_reg && (fill_reg >= sha256sh_pkg::LEN_START))
        begin
            push_byte = len_shift[63:56];
        end
    end

    always_comb
    begin
        sched_ctrl.byte_en  = push_en;
        sched_ctrl.round_en = (state_reg == ST_ROUND);
        sched_ctrl.early    = (round_reg[5:4] == 2'b00);
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        round_next  = round_reg;
        final_next  = final_reg;
        len_ok_next = len_ok_reg;
        idx_next    = idx_reg;
        hash_next   = hash_reg;
        work_next   = work_reg;

        if (push_en)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg == sha256sh_pkg::LAST_BYTE)
            begin
                state_next = ST_ROUND;
                round_next = '0;
                work_next  = hash_reg;
            end
            else if (in_fire && (s_axis_tuser == sha256sh_pkg::KIND_END))
            begin
                state_next = ST_PAD;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == sha256sh_pkg::KIND_DATA)
                    begin
                        count_next = count_reg + 61'd1;
                    end
                    else
                    begin
                        final_next  = 1'b1;
                        len_ok_next = (fill_reg < sha256sh_pkg::LEN_START);
                    end
                end
            end
            ST_PAD:
            begin
            end
            ST_ROUND:
            begin
                work_next  = round_out;
                round_next = round_reg + 6'd1;
                if (round_reg == sha256sh_pkg::LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                hash_next.a = hash_reg.a + work_reg.a;
                hash_next.b = hash_reg.b + work_reg.b;
                hash_next.c = hash_reg.c + work_reg.c;
                hash_next.d = hash_reg.d + work_reg.d;
                hash_next.e = hash_reg.e + work_reg.e;
                hash_next.f = hash_reg.f + work_reg.f;
                hash_next.g = hash_reg.g + work_reg.g;
                hash_next.h = hash_reg.h + work_reg.h;
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_ok_reg)
                begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end
                else
                begin
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha256sh_pkg::LAST_WORD_IDX)
                    begin
                        hash_next  = sha256sh_pkg::HASH_INIT;
                        count_next = '0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            count_reg  <= '0;
            round_reg  <= '0;
            final_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
            idx_reg    <= '0;
            hash_reg   <= sha256sh_pkg::HASH_INIT;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            round_reg  <= round_next;
            final_reg  <= final_next;
            len_ok_reg <= len_ok_next;
            idx_reg    <= idx_next;
            hash_reg   <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == sha256sh_pkg::LAST_WORD_IDX);

    always_comb
    begin
        unique case (idx_reg)
            3'd0: m_axis_tdata = hash_reg.a;
            3'd1: m_axis_tdata = hash_reg.b;
            3'd2: m_axis_tdata = hash_reg.c;
            3'd3: m_axis_tdata = hash_reg.d;
            3'd4: m_axis_tdata = hash_reg.e;
            3'd5: m_axis_tdata = hash_reg.f;
            3'd6: m_axis_tdata = hash_reg.g;
            3'd7: m_axis_tdata = hash_reg.h;
        endcase
    end

endmodule

FILE: design/sha256sh_checker.sv
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256sh_pkg and sha256_stream_hasher.

module sha256sh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic in_end_beat;
    logic out_beat;

    assign in_end_beat = s_axis_tvalid && s_axis_tready
                         && (s_axis_tuser == sha256sh_pkg::KIND_END);
    assign out_beat    = m_axis_tvalid && m_axis_tready;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while digest beats are pending");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == sha256sh_pkg::LAST_WORD_IDX)))
        else $error("last flag does not match word index");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && !m_axis_tlast) |=>
            (m_axis_tvalid && (m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1))))
        else $error("digest word index did not advance by one");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_end_beat |=> !s_axis_tready)
        else $error("input ready right after the end of a message");

    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("digest beats continue after the last word");

endmodule

bind sha256_stream_hasher sha256sh_checker u_checker (.*);
